[rtl/dtrt_pkg.sv]
// shared types, codes and helpers for the delimited text row tokenizer
package dtrt_pkg;

  localparam int MaxFields  = 32;
  localparam int MaxSeps    = 4;
  localparam int QueueDepth = 4;
  localparam int QueueAw    = $clog2(QueueDepth);

  typedef logic [2:0] kind_t;

  localparam kind_t KIND_DATA    = 3'd0;
  localparam kind_t KIND_VALUE   = 3'd1;
  localparam kind_t KIND_NULL    = 3'd2;
  localparam kind_t KIND_DEFAULT = 3'd3;
  localparam kind_t KIND_END     = 3'd4;

  typedef logic [2:0] cfg_addr_t;

  localparam cfg_addr_t CFG_MODE      = 3'd0;
  localparam cfg_addr_t CFG_ROW_CHARS = 3'd1;
  localparam cfg_addr_t CFG_ROW_COUNT = 3'd2;
  localparam cfg_addr_t CFG_COL_CHARS = 3'd3;
  localparam cfg_addr_t CFG_COL_COUNT = 3'd4;
  localparam cfg_addr_t CFG_FIELDS    = 3'd5;

  localparam logic [1:0] MODE_STRICT  = 2'd0;
  localparam logic [1:0] MODE_GENERAL = 2'd1;
  localparam logic [1:0] MODE_WEAK    = 2'd2;

  // one request from the classifier to the event generator
  typedef struct packed {
    kind_t       kind;
    logic [4:0]  field;
    logic [7:0]  data;
    logic        row_done;   // primary event finishes the row
    logic        dflt;       // default fields follow
    logic [5:0]  next_field; // first default field
    logic [5:0]  cnt;        // fields per row, clamped
  } cmd_t;

  function automatic logic in_set(input logic [31:0] chars, input logic [2:0] count,
                                  input logic [7:0] b);
    logic hit;
    hit = 1'b0;
    for (int k = 0; k < 4; k++) begin
      if (k < MaxSeps && 3'(k) < count && chars[8*k +: 8] == b) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

endpackage

[rtl/dtrt_queue.sv]
// short request queue between the classifier and the event generator
module dtrt_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  dtrt_pkg::cmd_t  push_cmd,
  output logic            full,
  input  logic            pop,
  output dtrt_pkg::cmd_t  head,
  output logic            empty
);

  dtrt_pkg::cmd_t                  mem_r [dtrt_pkg::QueueDepth];
  logic [dtrt_pkg::QueueAw-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [dtrt_pkg::QueueAw-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [dtrt_pkg::QueueAw:0]      count_r, count_nxt;

  assign full  = (count_r == (dtrt_pkg::QueueAw+1)'(dtrt_pkg::QueueDepth));
  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

[rtl/dtrt_front.sv]
// classifier: configuration registers, row/field tracking, request generation
module dtrt_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_wr_en,
  input  logic [2:0]      cfg_addr,
  input  logic [31:0]     cfg_wdata,
  input  logic            fire,
  input  logic [7:0]      text_byte,
  output logic            push,
  output dtrt_pkg::cmd_t  push_cmd
);

  logic [1:0]  mode_r;
  logic [31:0] row_chars_r;
  logic [2:0]  row_count_r;
  logic [31:0] col_chars_r;
  logic [2:0]  col_count_r;
  logic [5:0]  fields_r;

  logic [4:0]  cur_r, cur_nxt;
  logic        has_r, has_nxt;
  logic        blank_r, blank_nxt;
  logic        discard_r, discard_nxt;
  logic        ended_r, ended_nxt;

  logic        is_row, is_col;
  logic [5:0]  cnt;
  logic [5:0]  next_f;
  logic        skip;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= dtrt_pkg::MODE_GENERAL;
      row_chars_r <= 32'd10;
      row_count_r <= 3'd1;
      col_chars_r <= 32'h0000_0920;
      col_count_r <= 3'd2;
      fields_r    <= 6'd1;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        dtrt_pkg::CFG_MODE:      mode_r      <= cfg_wdata[1:0];
        dtrt_pkg::CFG_ROW_CHARS: row_chars_r <= cfg_wdata;
        dtrt_pkg::CFG_ROW_COUNT: row_count_r <= cfg_wdata[2:0];
        dtrt_pkg::CFG_COL_CHARS: col_chars_r <= cfg_wdata;
        dtrt_pkg::CFG_COL_COUNT: col_count_r <= cfg_wdata[2:0];
        dtrt_pkg::CFG_FIELDS:    fields_r    <= cfg_wdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (fields_r == 6'd0) begin
      cnt = 6'd1;
    end else if (fields_r > 6'(dtrt_pkg::MaxFields)) begin
      cnt = 6'(dtrt_pkg::MaxFields);
    end else begin
      cnt = fields_r;
    end
  end

  assign is_row = dtrt_pkg::in_set(row_chars_r, row_count_r, text_byte);
  assign is_col = dtrt_pkg::in_set(col_chars_r, col_count_r, text_byte);
  assign next_f = {1'b0, cur_r} + 6'd1;
  assign skip   = !has_r && ((mode_r != dtrt_pkg::MODE_STRICT && is_row && blank_r) ||
                             (mode_r[1] && is_col));

  always_comb begin
    cur_nxt     = cur_r;
    has_nxt     = has_r;
    blank_nxt   = blank_r;
    discard_nxt = discard_r;
    ended_nxt   = ended_r;
    push        = 1'b0;
    push_cmd.kind       = dtrt_pkg::KIND_DATA;
    push_cmd.field      = cur_r;
    push_cmd.data       = 8'd0;
    push_cmd.row_done   = 1'b0;
    push_cmd.dflt       = 1'b0;
    push_cmd.next_field = next_f;
    push_cmd.cnt        = cnt;
    if (fire && !ended_r) begin
      priority if (text_byte == 8'd0) begin
        push          = 1'b1;
        push_cmd.kind = dtrt_pkg::KIND_END;
        ended_nxt     = 1'b1;
      end else if (discard_r) begin
        if (is_row) begin
          discard_nxt = 1'b0;
        end
      end else if (skip) begin
        // separator swallowed, no event
      end else if (is_row || is_col) begin
        push              = 1'b1;
        push_cmd.kind     = has_r ? dtrt_pkg::KIND_VALUE : dtrt_pkg::KIND_NULL;
        push_cmd.row_done = (next_f >= cnt);
        if (is_row) begin
          // row separator: if the row ended early, the rest of the fields come as defaults
          push_cmd.dflt = (next_f < cnt);
          cur_nxt       = '0;
          has_nxt       = 1'b0;
          blank_nxt     = 1'b1;
        end else if (next_f >= cnt) begin
          cur_nxt     = '0;
          has_nxt     = 1'b0;
          blank_nxt   = 1'b1;
          discard_nxt = 1'b1;
        end else begin
          cur_nxt   = next_f[4:0];
          has_nxt   = 1'b0;
          blank_nxt = 1'b0;
        end
      end else begin
        push          = 1'b1;
        push_cmd.data = text_byte;
        has_nxt       = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r     <= '0;
      has_r     <= 1'b0;
      blank_r   <= 1'b1;
      discard_r <= 1'b0;
      ended_r   <= 1'b0;
    end else begin
      cur_r     <= cur_nxt;
      has_r     <= has_nxt;
      blank_r   <= blank_nxt;
      discard_r <= discard_nxt;
      ended_r   <= ended_nxt;
    end
  end

endmodule

[rtl/dtrt_back.sv]
// event generator: expands requests into events, default runs one per cycle while out_tready
module dtrt_back (
  input  logic            clk,
  input  logic            rst_n,
  input  dtrt_pkg::cmd_t  head,
  input  logic            q_empty,
  output logic            q_pop,
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [15:0]     out_tdata,  // [4:0] field_index, [12:5] data_value, [13] row_complete
  output logic [2:0]      out_tuser,  // [2:0] event_kind
  output logic            out_tlast   // last
);

  logic                valid_r, valid_nxt;
  logic                busy_r, busy_nxt;
  logic [5:0]          f_r, f_nxt;
  dtrt_pkg::kind_t     kind_r, kind_nxt;
  logic [4:0]          field_r, field_nxt;
  logic [7:0]          data_r, data_nxt;
  logic                done_r, done_nxt;
  logic                last_r, last_nxt;
  logic                load;
  logic                dflt_end;

  assign load     = !valid_r || out_tready;
  assign dflt_end = ((f_r + 6'd1) == head.cnt);

  always_comb begin
    valid_nxt = valid_r;
    busy_nxt  = busy_r;
    f_nxt     = f_r;
    kind_nxt  = kind_r;
    field_nxt = field_r;
    data_nxt  = data_r;
    done_nxt  = done_r;
    last_nxt  = last_r;
    q_pop     = 1'b0;
    if (load) begin
      valid_nxt = 1'b0;
      if (busy_r) begin
        valid_nxt = 1'b1;
        kind_nxt  = dtrt_pkg::KIND_DEFAULT;
        field_nxt = f_r[4:0];
        data_nxt  = 8'd0;
        done_nxt  = dflt_end;
        last_nxt  = dflt_end;
        if (dflt_end) begin
          q_pop    = 1'b1;
          busy_nxt = 1'b0;
        end else begin
          f_nxt = f_r + 6'd1;
        end
      end else if (!q_empty) begin
        valid_nxt = 1'b1;
        kind_nxt  = head.kind;
        field_nxt = head.field;
        data_nxt  = head.data;
        done_nxt  = head.row_done;
        if (head.dflt) begin
          busy_nxt = 1'b1;
          f_nxt    = head.next_field;
          last_nxt = 1'b0;
        end else begin
          q_pop    = 1'b1;
          last_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      busy_r  <= 1'b0;
      f_r     <= '0;
    end else begin
      valid_r <= valid_nxt;
      busy_r  <= busy_nxt;
      f_r     <= f_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r  <= kind_nxt;
    field_r <= field_nxt;
    data_r  <= data_nxt;
    done_r  <= done_nxt;
    last_r  <= last_nxt;
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {2'b00, done_r, data_r, field_r};
  assign out_tuser  = kind_r;
  assign out_tlast  = last_r;

endmodule

[rtl/delimited_text_row_tokenizer_unit.sv]
// top level of the delimited text row tokenizer
//
// Text enters one byte per request on the in_ stream (in_tdata[7:0]); a zero
// byte ends the data. Each byte yields zero or more events on the out_ stream:
// out_tuser is the event kind, out_tdata packs field index, data byte and row
// complete flag, out_tlast marks the final event caused by one byte.
// Separator sets, mode and field count sit behind the cfg_ write port and
// should be written while the stream is idle.
// Throughput: one byte per cycle while each byte gives at most one event and
// the receiver is ready. A row separator that closes a row early gives one
// event plus one default event per missing field, made by the event generator
// at one event per cycle unless the receiver stalls; a four-entry request
// queue absorbs that, and input stalls once it fills. Each byte's request is
// queued first, and its first event is then loaded into the output register.
// Reset restores the register defaults (general mode, newline rows, space and
// tab columns, one field) and starts a fresh row. After the end-of-data event
// every byte is taken and ignored until the next reset. A stalled receiver
// holds the output register; the queue keeps taking bytes until it is full.
module delimited_text_row_tokenizer_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_addr,
  input  logic [31:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] text_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [4:0] field_index, [12:5] data_value, [13] row_complete
  output logic [2:0]  out_tuser,  // [2:0] event_kind
  output logic        out_tlast   // last
);

  logic            in_fire;
  logic            q_push;
  logic            q_full;
  logic            q_pop;
  logic            q_empty;
  dtrt_pkg::cmd_t  q_in;
  dtrt_pkg::cmd_t  q_head;

  assign in_tready = !q_full;
  assign in_fire   = in_tvalid && in_tready;

  dtrt_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .fire      (in_fire),
    .text_byte (in_tdata),
    .push      (q_push),
    .push_cmd  (q_in)
  );

  dtrt_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_in),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty)
  );

  dtrt_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (q_head),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // a request is only written when the queue has room
  assert property (@(posedge clk) disable iff (!rst_n) q_push |-> !q_full)
    else $error("request pushed into full queue");

  // nothing follows the end-of-data event
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tuser == dtrt_pkg::KIND_END) |=> !out_tvalid)
    else $error("event after end of data");

  // the row-finishing event is always the last one of its byte
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[13]) |-> out_tlast)
    else $error("row complete without last");

  // popping needs a queued request
  assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> !q_empty)
    else $error("pop from empty queue");

endmodule
